/* rtl/cbmt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cbmt_pkg;

    // Counter width and the fixed widths of the request and result fields.
    localparam int COUNT_BITS      = 16;
    localparam int DEF_MAX_OBJECTS = 256;
    localparam int CFG_W           = 9;
    localparam int INDEX_W         = 8;
    localparam int MULT_W          = 9;

    // Signed limits of one counter.
    localparam logic signed [COUNT_BITS-1:0] CNT_HI = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] CNT_LO = {1'b1, {(COUNT_BITS-1){1'b0}}};

    // Request codes.
    localparam logic [1:0] REQ_INC   = 2'd0;
    localparam logic [1:0] REQ_DEC   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [INDEX_W-1:0] index;
    } t_req;

    typedef struct packed {
        logic signed [COUNT_BITS-1:0] count_value;
        logic signed [COUNT_BITS-1:0] max_value;
        logic [MULT_W-1:0]            num_at_max;
        logic                         index_error;
    } t_result;

endpackage

`default_nettype wire

/* rtl/counter_bank_with_max_tracking_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Bank of MAX_OBJECTS signed saturating counters held in one synchronous RAM,
// with the largest count and its multiplicity tracked alongside. A request is
// taken when start is high and busy is low; it is served by one RAM read and
// one write-back, and its result appears on o_result, marked by o_done high
// for exactly one cycle, while the next request may already be taken. When the
// only counter at the maximum drops, a rescan walks the RAM, one entry per
// cycle, over the objects in use before the result is given. After reset and
// after every write of objects_in_use, a clearing pass zeroes all MAX_OBJECTS
// RAM entries with busy held high. The receiver cannot stall the result transfer.
module counter_bank_with_max_tracking_core #(
    parameter int MAX_OBJECTS = cbmt_pkg::DEF_MAX_OBJECTS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [cbmt_pkg::CFG_W-1:0] i_cfg_wdata,
    input  wire logic                     start,
    output logic                          busy,
    input  wire cbmt_pkg::t_req           i_req,
    output logic                          o_done,
    output cbmt_pkg::t_result             o_result
);
    import cbmt_pkg::*;

    localparam int AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int MW = $clog2(MAX_OBJECTS + 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RMW,
        S_SCAN
    } t_state;

    t_state r_state;

    // Counter RAM.
    logic signed [COUNT_BITS-1:0] mem [MAX_OBJECTS];
    logic signed [COUNT_BITS-1:0] r_rd_data;
    logic [AW-1:0]                mem_ra;
    logic [AW-1:0]                mem_wa;
    logic signed [COUNT_BITS-1:0] mem_wd;
    logic                         mem_we;

    // Control and tracking state.
    logic [MW-1:0]                r_objects;
    logic [MW-1:0]                r_clr_cnt;
    logic [MW-1:0]                r_scan_cnt;
    logic                         r_pend;
    logic                         r_first;
    logic signed [COUNT_BITS-1:0] r_max;
    logic [MW-1:0]                r_mult;
    logic signed [COUNT_BITS-1:0] r_cnt;
    t_req                         r_req;
    logic                         r_err;
    logic                         r_done;
    t_result                      r_result;

    logic [MW-1:0]                cfg_clamped;
    logic                         req_err;
    logic signed [COUNT_BITS-1:0] after_cnt;
    logic signed [COUNT_BITS-1:0] trk_max;
    logic [MW-1:0]                trk_mult;
    logic                         need_scan;
    logic signed [COUNT_BITS-1:0] scan_max;
    logic [MW-1:0]                scan_mult;

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    // Range check of the incoming index against the objects in use.
    assign req_err = (32'(i_req.index) >= 32'(r_objects));

    // Clamp a written object count into 1..MAX_OBJECTS.
    always_comb begin
        if (i_cfg_wdata == '0) begin
            cfg_clamped = MW'(1);
        end else if (32'(i_cfg_wdata) > MAX_OBJECTS) begin
            cfg_clamped = MW'(MAX_OBJECTS);
        end else begin
            cfg_clamped = MW'(i_cfg_wdata);
        end
    end

    // Read address: the scan pointer during a rescan, the request's index otherwise.
    assign mem_ra = (r_state == S_SCAN) ? r_scan_cnt[AW-1:0] : AW'(i_req.index);

    // Write port: zeroes during the clearing pass, the new count on write-back.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = AW'(r_req.index);
        mem_wd = after_cnt;
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = r_clr_cnt[AW-1:0];
            mem_wd = '0;
        end else if (r_state == S_RMW && !r_err) begin
            mem_we = 1'b1;
            mem_wa = AW'(r_req.index);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[mem_ra];
    end

    // New count with saturation at the signed limits.
    always_comb begin
        after_cnt = r_rd_data;
        unique case (r_req.req_type)
            REQ_INC: begin
                if (r_rd_data < CNT_HI) begin
                    after_cnt = r_rd_data + COUNT_BITS'(1);
                end
            end
            REQ_DEC: begin
                if (r_rd_data > CNT_LO) begin
                    after_cnt = r_rd_data - COUNT_BITS'(1);
                end
            end
            REQ_CLEAR: after_cnt = '0;
            REQ_READ:  after_cnt = r_rd_data;
            default:   after_cnt = r_rd_data;
        endcase
    end

    // Incremental update of the maximum and its multiplicity.
    always_comb begin
        trk_max   = r_max;
        trk_mult  = r_mult;
        need_scan = 1'b0;
        if (after_cnt > r_rd_data) begin
            if (after_cnt > r_max) begin
                trk_max  = after_cnt;
                trk_mult = MW'(1);
            end else if (after_cnt == r_max) begin
                trk_mult = r_mult + MW'(1);
            end
        end else if (after_cnt < r_rd_data && r_rd_data == r_max) begin
            if (r_mult > MW'(1)) begin
                trk_mult = r_mult - MW'(1);
            end else begin
                need_scan = 1'b1;
            end
        end
    end

    // One step of the rescan on the entry that arrived from the RAM.
    always_comb begin
        scan_max  = r_max;
        scan_mult = r_mult;
        if (r_pend) begin
            if (r_first || r_rd_data > r_max) begin
                scan_max  = r_rd_data;
                scan_mult = MW'(1);
            end else if (r_rd_data == r_max) begin
                scan_mult = r_mult + MW'(1);
            end
        end
    end

    // Sequencer with the registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
            r_objects <= MW'(MAX_OBJECTS);
            r_max     <= '0;
            r_mult    <= MW'(MAX_OBJECTS);
            r_done    <= 1'b0;
            r_pend    <= 1'b0;
            r_first   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                r_objects <= cfg_clamped;
                r_max     <= '0;
                r_mult    <= cfg_clamped;
                r_clr_cnt <= '0;
                r_state   <= S_CLEAR;
            end else begin
                unique case (r_state)
                    S_CLEAR: begin
                        r_clr_cnt <= r_clr_cnt + MW'(1);
                        if (r_clr_cnt == MW'(MAX_OBJECTS - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (start) begin
                            r_req   <= i_req;
                            r_err   <= req_err;
                            r_state <= S_RMW;
                        end
                    end
                    S_RMW: begin
                        if (r_err) begin
                            r_result.count_value <= '0;
                            r_result.max_value   <= r_max;
                            r_result.num_at_max  <= MULT_W'(r_mult);
                            r_result.index_error <= 1'b1;
                            r_done               <= 1'b1;
                            r_state              <= S_IDLE;
                        end else if (need_scan) begin
                            r_cnt      <= after_cnt;
                            r_scan_cnt <= '0;
                            r_pend     <= 1'b0;
                            r_first    <= 1'b1;
                            r_state    <= S_SCAN;
                        end else begin
                            r_max                <= trk_max;
                            r_mult               <= trk_mult;
                            r_result.count_value <= after_cnt;
                            r_result.max_value   <= trk_max;
                            r_result.num_at_max  <= MULT_W'(trk_mult);
                            r_result.index_error <= 1'b0;
                            r_done               <= 1'b1;
                            r_state              <= S_IDLE;
                        end
                    end
                    S_SCAN: begin
                        r_max  <= scan_max;
                        r_mult <= scan_mult;
                        if (r_pend) begin
                            r_first <= 1'b0;
                        end
                        if (r_scan_cnt != r_objects) begin
                            r_scan_cnt <= r_scan_cnt + MW'(1);
                            r_pend     <= 1'b1;
                        end else begin
                            r_pend <= 1'b0;
                            if (r_pend) begin
                                r_result.count_value <= r_cnt;
                                r_result.max_value   <= scan_max;
                                r_result.num_at_max  <= MULT_W'(scan_mult);
                                r_result.index_error <= 1'b0;
                                r_done               <= 1'b1;
                                r_state              <= S_IDLE;
                            end
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

endmodule

`default_nettype wire
